// ===== design/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// constants and round functions shared by the sha-256 / sha-224 hasher
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int HashWords = 8;

	typedef logic [31:0] word_t;

	function automatic word_t round_k(input logic [5:0] i);
		word_t k;
		unique case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t init_word(input logic mode, input logic [2:0] i);
		word_t v;
		unique case ({mode, i})
			4'h0: v = 32'h6a09e667; 4'h1: v = 32'hbb67ae85; 4'h2: v = 32'h3c6ef372;
			4'h3: v = 32'ha54ff53a; 4'h4: v = 32'h510e527f; 4'h5: v = 32'h9b05688c;
			4'h6: v = 32'h1f83d9ab; 4'h7: v = 32'h5be0cd19; 4'h8: v = 32'hc1059ed8;
			4'h9: v = 32'h367cd507; 4'ha: v = 32'h3070dd17; 4'hb: v = 32'hf70e5939;
			4'hc: v = 32'hffc00b31; 4'hd: v = 32'h68581511; 4'he: v = 32'h64f98fa7;
			default: v = 32'hbefa4fa4;
		endcase
		return v;
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== design/sha256_byte_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// byte-serial sha-256 / sha-224 hasher with one shared round unit
// ----------------------------------------------------------------------------
// s_axis carries one item per byte: tuser is the action (0 absorb, 1 finish),
// tdata is the message byte. cfg writes digest_mode (0 sha-256, 1 sha-224)
// and restarts the message; write it only while the block is idle.
// an absorb item is written straight into the block buffer, except the 64th
// byte of a block, which runs the compression: a load of the working
// variables, 64 rounds of the shared round unit, one per cycle, and an add
// into the hash words.
// a finish item writes the padding one byte a cycle into the block buffer,
// compresses once or twice, then sends 8 (or 7) digest words on m_axis,
// word_index in tuser and tlast on the final word. s_axis_tready is low
// from acceptance until the last word is taken; a stalled receiver holds
// the word in the output register. reset loads the sha-256 initial values,
// clears the byte position, bit count and mode; the buffer is not cleared.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic [0:0]  s_axis_tuser,   // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // digest_word
	output logic [2:0]  m_axis_tuser,   // word_index
	output logic        m_axis_tlast    // last_word
);

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StPad  = 3'd1;
	localparam logic [2:0] StLoad = 3'd2;
	localparam logic [2:0] StRnd  = 3'd3;
	localparam logic [2:0] StAdd  = 3'd4;
	localparam logic [2:0] StOut  = 3'd5;

	logic [2:0] state_q;
	logic mode_q;
	logic fin_q;
	sha_pkg::word_t h_q [sha_pkg::HashWords];
	sha_pkg::word_t v_q [8];
	sha_pkg::word_t w_q [16];
	logic [5:0] pos_q;
	logic [63:0] bits_q;
	logic [5:0] rnd_q;
	logic ld_q;
	logic [2:0] oi_q;
	logic ov_q;
	logic [31:0] od_q;
	logic ol_q;

	logic s_acc, cfg_acc;
	assign cfg_ready = (state_q == StIdle);
	assign cfg_acc = cfg_valid && cfg_ready;
	assign s_axis_tready = (state_q == StIdle) && !cfg_valid;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// block bytes go straight into the schedule words, big-endian
	logic byte_we;
	logic [7:0] byte_d;
	always_comb begin
		byte_we = 1'b0;
		byte_d = 8'h00;
		if (s_acc) begin
			byte_we = 1'b1;
			byte_d = s_axis_tuser[0] ? 8'h80 : s_axis_tdata;
		end else if (state_q == StPad) begin
			byte_we = 1'b1;
			if (pos_q >= 6'd56 && fin_q && ld_q) begin
				byte_d = 8'(bits_q >> {~pos_q[2:0], 3'b000});
			end
		end
	end

	// schedule and round datapath
	sha_pkg::word_t w2, w15, s0, s1, wn, wr, t1, t2, a, b, c, e, f, g;
	always_comb begin
		w2 = w_q[4'(rnd_q - 6'd2)];
		w15 = w_q[4'(rnd_q - 6'd15)];
		s0 = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
		s1 = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
		wn = s1 + w_q[4'(rnd_q - 6'd7)] + s0 + w_q[rnd_q[3:0]];
		wr = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]] : wn;
		a = v_q[0]; b = v_q[1]; c = v_q[2];
		e = v_q[4]; f = v_q[5]; g = v_q[6];
		t1 = v_q[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
			+ (g ^ (e & (f ^ g))) + sha_pkg::round_k(rnd_q) + wr;
		t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
			+ ((a & b) | (c & (a | b)));
	end

	always_ff @(posedge clk) begin
		if (byte_we) begin
			unique case (pos_q[1:0])
				2'd0: w_q[pos_q[5:2]][31:24] <= byte_d;
				2'd1: w_q[pos_q[5:2]][23:16] <= byte_d;
				2'd2: w_q[pos_q[5:2]][15:8] <= byte_d;
				default: w_q[pos_q[5:2]][7:0] <= byte_d;
			endcase
		end else if (state_q == StLoad) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (state_q == StRnd) begin
			if (rnd_q >= 6'd16) begin
				w_q[rnd_q[3:0]] <= wn;
			end
			v_q[7] <= g; v_q[6] <= f; v_q[5] <= e; v_q[4] <= v_q[3] + t1;
			v_q[3] <= c; v_q[2] <= b; v_q[1] <= a; v_q[0] <= t1 + t2;
		end
	end

	// ld_q marks the pass that writes the length bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			mode_q <= 1'b0;
			fin_q <= 1'b0;
			pos_q <= '0;
			bits_q <= '0;
			rnd_q <= '0;
			ld_q <= 1'b0;
			oi_q <= '0;
			ov_q <= 1'b0;
			od_q <= '0;
			ol_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::init_word(1'b0, 3'(i));
			end
		end else begin
			unique case (state_q)
				StIdle: begin
					if (cfg_acc) begin
						mode_q <= cfg_data[0];
						pos_q <= '0;
						bits_q <= '0;
						for (int i = 0; i < 8; i++) begin
							h_q[i] <= sha_pkg::init_word(cfg_data[0], 3'(i));
						end
					end else if (s_acc && s_axis_tuser[0] == 1'b0) begin
						pos_q <= pos_q + 6'd1;
						bits_q <= bits_q + 64'd8;
						fin_q <= 1'b0;
						if (pos_q == 6'd63) begin
							state_q <= StLoad;
						end
					end else if (s_acc) begin
						fin_q <= 1'b1;
						ld_q <= (pos_q < 6'd56);
						pos_q <= pos_q + 6'd1;
						state_q <= (pos_q == 6'd63) ? StLoad : StPad;
					end
				end
				StPad: begin
					pos_q <= pos_q + 6'd1;
					if (pos_q == 6'd63) begin
						state_q <= StLoad;
					end
				end
				StLoad: begin
					rnd_q <= '0;
					state_q <= StRnd;
				end
				StRnd: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= StAdd;
					end
				end
				StAdd: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					if (!fin_q) begin
						state_q <= StIdle;
					end else if (!ld_q) begin
						ld_q <= 1'b1;
						state_q <= StPad;
					end else begin
						oi_q <= '0;
						od_q <= h_q[0] + v_q[0];
						ol_q <= 1'b0;
						ov_q <= 1'b1;
						state_q <= StOut;
					end
				end
				StOut: begin
					if (m_axis_tready) begin
						if (ol_q) begin
							ov_q <= 1'b0;
							fin_q <= 1'b0;
							pos_q <= '0;
							bits_q <= '0;
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= sha_pkg::init_word(mode_q, 3'(i));
							end
							state_q <= StIdle;
						end else begin
							oi_q <= oi_q + 3'd1;
							od_q <= h_q[oi_q + 3'd1];
							ol_q <= (oi_q + 3'd1) == (mode_q ? 3'd6 : 3'd7);
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = od_q;
	assign m_axis_tuser = oi_q;
	assign m_axis_tlast = ol_q;

endmodule

// ===== bench/sha_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha_checker
// watches the cfg, byte and digest channels of the hasher, computes the
// expected sha-256 / sha-224 digest words and compares each digest item
// ----------------------------------------------------------------------------
module sha_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic [0:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          words_pending
);

	typedef struct packed {
		sha_pkg::word_t word;
		logic [2:0]     index;
		logic           last;
	} digest_item_t;

	localparam sha_pkg::word_t K[64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam sha_pkg::word_t IV256[8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam sha_pkg::word_t IV224[8] = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	logic           mode;
	sha_pkg::word_t hash[8];
	logic [7:0]     block[64];
	logic [5:0]     fill;
	logic [63:0]    msg_bits;
	digest_item_t   digest_queue[$];
	int             mismatches;

	assign fail_count = mismatches;
	assign words_pending = digest_queue.size();

	function automatic sha_pkg::word_t ror(input sha_pkg::word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic restart_message();
		for (int i = 0; i < 8; i++)
			hash[i] = mode ? IV224[i] : IV256[i];
		fill = '0;
		msg_bits = '0;
	endtask

	task automatic compress_block();
		sha_pkg::word_t w[64];
		sha_pkg::word_t v[8];
		sha_pkg::word_t t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		for (int i = 0; i < 8; i++)
			v[i] = hash[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ (v[6] ^ (v[4] & (v[5] ^ v[6]))) + K[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash[i] += v[i];
	endtask

	task automatic finish_message();
		int pos;
		int count;
		digest_item_t d;
		pos = fill;
		block[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				block[pos] = '0;
				pos++;
			end
			compress_block();
			pos = 0;
		end
		while (pos < 56) begin
			block[pos] = '0;
			pos++;
		end
		for (int k = 0; k < 8; k++)
			block[56+k] = msg_bits[63-8*k -: 8];
		compress_block();
		count = mode ? 7 : 8;
		for (int k = 0; k < count; k++) begin
			d.word = hash[k];
			d.index = k[2:0];
			d.last = (k == count - 1);
			digest_queue.push_back(d);
		end
		restart_message();
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_item_t exp_item;
		if (!arst_n) begin
			mode = 1'b0;
			restart_message();
			digest_queue.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode = cfg_data[0];
				restart_message();
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser[0]) begin
					finish_message();
				end else begin
					block[fill] = s_axis_tdata;
					fill = fill + 6'd1;
					if (fill == 0)
						compress_block();
					msg_bits += 64'd8;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected digest item: word %h index %0d last %b",
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					exp_item = digest_queue.pop_front();
					if (exp_item.word !== m_axis_tdata || exp_item.index !== m_axis_tuser
						|| exp_item.last !== m_axis_tlast) begin
						mismatches++;
						if (mismatches <= 10)
							$display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
								exp_item.word, exp_item.index, exp_item.last,
								m_axis_tdata, m_axis_tuser, m_axis_tlast);
					end
				end
			end
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives byte messages and finish items into the sha-256 / sha-224 hasher
// in four stall phases and both modes; sha_checker predicts and compares
// ----------------------------------------------------------------------------
module tb_top;

	localparam int StallLimit = 6000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // data_byte
	logic [0:0]  s_axis_tuser;   // action
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // digest_word
	logic [2:0]  m_axis_tuser;   // word_index
	logic        m_axis_tlast;   // last_word
	int          fail_count;
	int          words_pending;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          quiet_cycles;

	localparam logic [0:0] ActAbsorb = 1'b0;
	localparam logic [0:0] ActFinish = 1'b1;
	localparam logic [0:0] ModeSha256 = 1'b0;
	localparam logic [0:0] ModeSha224 = 1'b1;

	sha256_byte_stream_hasher_unit dut (.*);

	sha_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == StallLimit) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic send_item(input logic [0:0] action, input logic [7:0] data);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = action;
		s_axis_tdata = data;
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
	endtask

	task automatic release_bytes();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic write_mode(input logic [0:0] mode);
		release_bytes();
		while (words_pending != 0)
			@(negedge clk);
		// a final absorb may still be compressing
		repeat (100) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = mode;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_item(ActAbsorb, 8'($urandom));
		send_item(ActFinish, 8'($urandom));
	endtask

	initial begin
		int sent;
		int len;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = ModeSha256;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ActAbsorb;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty message, extreme bytes, finish carrying a nonzero byte
		send_item(ActFinish, 8'h00);
		send_item(ActAbsorb, 8'h00);
		send_item(ActAbsorb, 8'hff);
		send_item(ActAbsorb, 8'h55);
		send_item(ActAbsorb, 8'haa);
		send_item(ActFinish, 8'hff);
		send_item(ActAbsorb, 8'h61);
		send_item(ActAbsorb, 8'h62);
		send_item(ActAbsorb, 8'h63);
		send_item(ActFinish, 8'h00);
		// bytes before a mode write are discarded
		send_item(ActAbsorb, 8'h12);
		send_item(ActAbsorb, 8'h34);
		write_mode(ModeSha224);
		send_item(ActFinish, 8'h00);
		send_item(ActAbsorb, 8'h80);
		send_item(ActAbsorb, 8'h01);
		send_item(ActFinish, 8'h7f);
		write_mode(ModeSha256);

		sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
				1: begin send_idle_pct = 68; recv_idle_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_idle_pct = 68; end
				default: begin send_idle_pct = 38; recv_idle_pct = 38; end
			endcase
			write_mode(phase[0] ? ModeSha224 : ModeSha256);
			while (sent < 92 * (phase + 1)) begin
				case ($urandom_range(9))
					0: len = 55 + $urandom_range(9);
					1: len = $urandom_range(130);
					default: len = $urandom_range(20);
				endcase
				send_message(len);
				sent += len + 1;
			end
			// stretch with no idling inside each phase
			send_idle_pct = 0;
			recv_idle_pct = 0;
			send_message($urandom_range(8));
		end

		release_bytes();
		while (words_pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0 && words_pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
